[hdl/lru_pkg.sv]
// Shared constants and control structs for the LRU page replacement block.
package lru_pkg;

	// Field widths fixed by the block's interface.
	localparam int CFG_W      = 5;
	localparam int SLOT_OUT_W = 4;
	localparam int FAULT_W    = 32;
	localparam int RANK_W     = 4;

	// Defaults for the top-level parameters.
	localparam int DEF_MAX_FRAME_COUNT = 16;
	localparam int DEF_PAGE_BITS       = 16;

	// Number of frames in use after reset.
	localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(16);

	// Fault counter value at which it stops counting.
	localparam logic [FAULT_W-1:0] FAULT_MAX = '1;

	// Search token flags that ripple from cell to cell.
	typedef struct packed {
		logic              valid;
		logic              hit_found;
		logic              empty_found;
		logic [RANK_W-1:0] hit_rank;
		logic [RANK_W-1:0] best_rank;
	} lru_tok_t;

	// Update command broadcast to every cell when a reference completes.
	typedef struct packed {
		logic              fire;
		logic              was_valid;
		logic              write_page;
		logic [RANK_W-1:0] old_rank;
	} lru_upd_t;

endpackage

[hdl/lru_cell.sv]
// One frame cell: holds a page, valid bit and recency rank, and steps the search token.
module lru_cell #(
	parameter int MAX_FRAME_COUNT = lru_pkg::DEF_MAX_FRAME_COUNT,
	parameter int PAGE_BITS       = lru_pkg::DEF_PAGE_BITS,
	parameter int INDEX           = 0,
	parameter int SLOT_W          = (MAX_FRAME_COUNT > 1) ? $clog2(MAX_FRAME_COUNT) : 1,
	parameter int CNT_W           = $clog2(MAX_FRAME_COUNT + 1)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [CNT_W-1:0]     used,
	input  logic                 clear,
	input  lru_pkg::lru_upd_t    upd,
	input  logic [SLOT_W-1:0]    upd_slot,
	input  logic [PAGE_BITS-1:0] upd_page,
	input  lru_pkg::lru_tok_t    tok_in,
	input  logic [PAGE_BITS-1:0] tok_in_page,
	input  logic [SLOT_W-1:0]    tok_in_hit_slot,
	input  logic [SLOT_W-1:0]    tok_in_empty_slot,
	input  logic [SLOT_W-1:0]    tok_in_best_slot,
	input  logic [PAGE_BITS-1:0] tok_in_best_page,
	output lru_pkg::lru_tok_t    tok_out,
	output logic [PAGE_BITS-1:0] tok_out_page,
	output logic [SLOT_W-1:0]    tok_out_hit_slot,
	output logic [SLOT_W-1:0]    tok_out_empty_slot,
	output logic [SLOT_W-1:0]    tok_out_best_slot,
	output logic [PAGE_BITS-1:0] tok_out_best_page
);
	import lru_pkg::*;

	localparam int RANK_TOP = (MAX_FRAME_COUNT - 1 > 15) ? 15 : MAX_FRAME_COUNT - 1;
	localparam logic [SLOT_W-1:0] MY_SLOT = SLOT_W'(INDEX);
	localparam logic [CNT_W-1:0]  MY_CNT  = CNT_W'(INDEX);
	localparam bit FIRST = (INDEX == 0);

	logic [PAGE_BITS-1:0] page_q;
	logic                 valid_q;
	logic [RANK_W-1:0]    rank_q;
	logic                 in_use;
	lru_tok_t             nxt;
	logic [SLOT_W-1:0]    nxt_hit_slot;
	logic [SLOT_W-1:0]    nxt_empty_slot;
	logic [SLOT_W-1:0]    nxt_best_slot;
	logic [PAGE_BITS-1:0] nxt_best_page;
	logic                 is_target;
	logic                 ages;

	// Only frames below the configured count are searched or chosen.
	assign in_use = (MY_CNT < used);

	// Fold this frame into the running search token.
	always_comb begin
		nxt            = tok_in;
		nxt_hit_slot   = tok_in_hit_slot;
		nxt_empty_slot = tok_in_empty_slot;
		nxt_best_slot  = tok_in_best_slot;
		nxt_best_page  = tok_in_best_page;
		if (in_use && valid_q && (page_q == tok_in_page) && !tok_in.hit_found) begin
			nxt.hit_found = 1'b1;
			nxt.hit_rank  = rank_q;
			nxt_hit_slot  = MY_SLOT;
		end
		if (in_use && !valid_q && !tok_in.empty_found) begin
			nxt.empty_found = 1'b1;
			nxt_empty_slot  = MY_SLOT;
		end
		// Strictly greater keeps the lowest index among equal ranks.
		if (in_use && (FIRST || (rank_q > tok_in.best_rank))) begin
			nxt.best_rank = rank_q;
			nxt_best_slot = MY_SLOT;
			nxt_best_page = page_q;
		end
	end

	// Token flags register; only the valid bit matters at reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_out <= '0;
		end else begin
			tok_out <= nxt;
		end
	end

	// Token payload registers.
	always_ff @(posedge clk) begin
		tok_out_page       <= tok_in_page;
		tok_out_hit_slot   <= nxt_hit_slot;
		tok_out_empty_slot <= nxt_empty_slot;
		tok_out_best_slot  <= nxt_best_slot;
		tok_out_best_page  <= nxt_best_page;
	end

	// Decide how this frame reacts to the completing reference.
	assign is_target = (upd_slot == MY_SLOT);
	assign ages      = valid_q && (!upd.was_valid || (rank_q < upd.old_rank))
		&& (rank_q < RANK_W'(RANK_TOP));

	// Valid bit and recency rank; a restart clears both ahead of anything else.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			rank_q  <= '0;
		end else if (clear) begin
			valid_q <= 1'b0;
			rank_q  <= '0;
		end else if (upd.fire) begin
			if (is_target) begin
				valid_q <= 1'b1;
				rank_q  <= '0;
			end else if (ages) begin
				rank_q <= rank_q + RANK_W'(1);
			end
		end
	end

	// Page number, written only when a fault loads this frame.
	always_ff @(posedge clk) begin
		if (upd.fire && is_target && upd.write_page) begin
			page_q <= upd_page;
		end
	end

endmodule

[hdl/lru_page_replacement.sv]
// Top level of the LRU page replacement block: cell row, decision stage and result register.
//
// Each accepted page reference is carried by a search token that steps through a row of
// MAX_FRAME_COUNT frame cells, one cell per clock, collecting the first hit, the first
// empty frame and the least recently used frame. A decision register then holds the choice,
// and once the result register is free all cells update their ranks together while the
// result is loaded into it. A new reference is taken on the edge at which the previous
// result is loaded, so only one reference is in flight at a time; the token ripple
// through the cell row sets how long each reference takes.
// frames_in_use is written through cfg_we/cfg_wdata; the user must write it only while
// the block is idle, which the block itself does not enforce; 0 acts as 1 and values above
// MAX_FRAME_COUNT act as MAX_FRAME_COUNT.
module lru_page_replacement #(
	parameter int MAX_FRAME_COUNT = lru_pkg::DEF_MAX_FRAME_COUNT,
	parameter int PAGE_BITS       = lru_pkg::DEF_PAGE_BITS
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [lru_pkg::CFG_W-1:0]      cfg_wdata,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [PAGE_BITS-1:0]           page,
	input  logic                           restart,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic                           hit,
	output logic [lru_pkg::SLOT_OUT_W-1:0] frame_slot,
	output logic                           evicted_valid,
	output logic [PAGE_BITS-1:0]           evicted_page,
	output logic [lru_pkg::FAULT_W-1:0]    fault_count
);
	import lru_pkg::*;

	localparam int SLOT_W = (MAX_FRAME_COUNT > 1) ? $clog2(MAX_FRAME_COUNT) : 1;
	localparam int CNT_W  = $clog2(MAX_FRAME_COUNT + 1);
	localparam int CMP_W  = (CNT_W > CFG_W) ? CNT_W : CFG_W;

	// Configuration and frame count in use.
	logic [CFG_W-1:0] cfg_q;
	logic [CMP_W-1:0] cfg_ext;
	logic [CNT_W-1:0] used;

	// Token chain between cells; entry 0 is loaded here, entry k comes from cell k-1.
	lru_tok_t             tok          [MAX_FRAME_COUNT+1];
	logic [PAGE_BITS-1:0] tok_page     [MAX_FRAME_COUNT+1];
	logic [SLOT_W-1:0]    tok_hit_slot [MAX_FRAME_COUNT+1];
	logic [SLOT_W-1:0]    tok_emp_slot [MAX_FRAME_COUNT+1];
	logic [SLOT_W-1:0]    tok_bst_slot [MAX_FRAME_COUNT+1];
	logic [PAGE_BITS-1:0] tok_bst_page [MAX_FRAME_COUNT+1];
	logic [MAX_FRAME_COUNT:0] tok_valid;

	logic                 tok0_valid_q;
	lru_tok_t             tok0;
	logic [PAGE_BITS-1:0] tok0_page_q;

	// Handshake and control.
	logic accept;
	logic fire;
	logic out_free;
	logic busy_q;
	logic clear;

	// Decision stage.
	lru_tok_t             last;
	logic [SLOT_W-1:0]    d_slot;
	logic                 d_was_valid;
	logic [RANK_W-1:0]    d_old_rank;
	logic                 d_evict;
	logic [PAGE_BITS-1:0] d_evict_page;

	logic                 done_q;
	logic                 done_hit_q;
	logic [SLOT_W-1:0]    done_slot_q;
	logic                 done_was_valid_q;
	logic [RANK_W-1:0]    done_old_rank_q;
	logic                 done_evict_q;
	logic [PAGE_BITS-1:0] done_evict_page_q;
	logic [PAGE_BITS-1:0] done_page_q;

	// Fault counter and result register.
	logic [FAULT_W-1:0]   faults_q;
	logic [FAULT_W-1:0]   faults_nxt;
	lru_upd_t             upd;

	logic                  out_valid_q;
	logic                  out_hit_q;
	logic [SLOT_W-1:0]     out_slot_q;
	logic                  out_evict_q;
	logic [PAGE_BITS-1:0]  out_evict_page_q;
	logic [FAULT_W-1:0]    out_faults_q;

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_we) begin
			cfg_q <= cfg_wdata;
		end
	end

	// Clamp the configured count into 1..MAX_FRAME_COUNT.
	assign cfg_ext = CMP_W'(cfg_q);
	always_comb begin
		if (cfg_ext == '0) begin
			used = CNT_W'(1);
		end else if (cfg_ext > CMP_W'(MAX_FRAME_COUNT)) begin
			used = CNT_W'(MAX_FRAME_COUNT);
		end else begin
			used = CNT_W'(cfg_ext);
		end
	end

	// Handshake: one reference in flight, the next taken as the current one completes.
	assign out_free = !out_valid_q || !out_stall;
	assign fire     = done_q && out_free;
	assign in_stall = busy_q && !fire;
	assign accept   = in_valid && !in_stall;
	assign clear    = accept && restart;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (accept) begin
			busy_q <= 1'b1;
		end else if (fire) begin
			busy_q <= 1'b0;
		end
	end

	// Launch a fresh search token on each input transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok0_valid_q <= 1'b0;
		end else begin
			tok0_valid_q <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			tok0_page_q <= page;
		end
	end

	// A fresh token carries no findings yet.
	always_comb begin
		tok0       = '0;
		tok0.valid = tok0_valid_q;
	end

	assign tok[0]          = tok0;
	assign tok_page[0]     = tok0_page_q;
	assign tok_hit_slot[0] = '0;
	assign tok_emp_slot[0] = '0;
	assign tok_bst_slot[0] = '0;
	assign tok_bst_page[0] = '0;

	// Broadcast update for the reference being completed.
	always_comb begin
		upd.fire       = fire;
		upd.was_valid  = done_was_valid_q;
		upd.write_page = !done_hit_q;
		upd.old_rank   = done_old_rank_q;
	end

	// Row of frame cells.
	for (genvar i = 0; i < MAX_FRAME_COUNT; i++) begin : g_cell
		lru_cell #(
			.MAX_FRAME_COUNT (MAX_FRAME_COUNT),
			.PAGE_BITS       (PAGE_BITS),
			.INDEX           (i),
			.SLOT_W          (SLOT_W),
			.CNT_W           (CNT_W)
		) u_cell (
			.clk                (clk),
			.arst_n             (arst_n),
			.used               (used),
			.clear              (clear),
			.upd                (upd),
			.upd_slot           (done_slot_q),
			.upd_page           (done_page_q),
			.tok_in             (tok[i]),
			.tok_in_page        (tok_page[i]),
			.tok_in_hit_slot    (tok_hit_slot[i]),
			.tok_in_empty_slot  (tok_emp_slot[i]),
			.tok_in_best_slot   (tok_bst_slot[i]),
			.tok_in_best_page   (tok_bst_page[i]),
			.tok_out            (tok[i+1]),
			.tok_out_page       (tok_page[i+1]),
			.tok_out_hit_slot   (tok_hit_slot[i+1]),
			.tok_out_empty_slot (tok_emp_slot[i+1]),
			.tok_out_best_slot  (tok_bst_slot[i+1]),
			.tok_out_best_page  (tok_bst_page[i+1])
		);
	end

	for (genvar k = 0; k <= MAX_FRAME_COUNT; k++) begin : g_tv
		assign tok_valid[k] = tok[k].valid;
	end

	// Pick hit, else first empty frame, else the least recently used frame.
	assign last = tok[MAX_FRAME_COUNT];
	always_comb begin
		if (last.hit_found) begin
			d_slot = tok_hit_slot[MAX_FRAME_COUNT];
		end else if (last.empty_found) begin
			d_slot = tok_emp_slot[MAX_FRAME_COUNT];
		end else begin
			d_slot = tok_bst_slot[MAX_FRAME_COUNT];
		end
		d_was_valid  = last.hit_found || !last.empty_found;
		d_old_rank   = last.hit_found ? last.hit_rank : last.best_rank;
		d_evict      = !last.hit_found && !last.empty_found;
		d_evict_page = d_evict ? tok_bst_page[MAX_FRAME_COUNT] : '0;
	end

	// Decision register, held until the result register can take it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else if (last.valid) begin
			done_q <= 1'b1;
		end else if (fire) begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (last.valid) begin
			done_hit_q        <= last.hit_found;
			done_slot_q       <= d_slot;
			done_was_valid_q  <= d_was_valid;
			done_old_rank_q   <= d_old_rank;
			done_evict_q      <= d_evict;
			done_evict_page_q <= d_evict_page;
			done_page_q       <= tok_page[MAX_FRAME_COUNT];
		end
	end

	// Saturating fault counter; a restart clears it.
	assign faults_nxt = (done_hit_q || (faults_q == FAULT_MAX)) ?
		faults_q : faults_q + FAULT_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			faults_q <= '0;
		end else if (clear) begin
			faults_q <= '0;
		end else if (fire) begin
			faults_q <= faults_nxt;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			out_hit_q        <= done_hit_q;
			out_slot_q       <= done_slot_q;
			out_evict_q      <= done_evict_q;
			out_evict_page_q <= done_evict_page_q;
			out_faults_q     <= faults_nxt;
		end
	end

	assign out_valid     = out_valid_q;
	assign hit           = out_hit_q;
	assign frame_slot    = SLOT_OUT_W'(out_slot_q);
	assign evicted_valid = out_evict_q;
	assign evicted_page  = out_evict_page_q;
	assign fault_count   = out_faults_q;

`ifndef SYNTHESIS
	// At most one reference is anywhere in the token row or decision stage.
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({tok_valid, done_q}))
		else $error("more than one reference in flight");

	// While busy, the reference is somewhere in the row or the decision stage.
	a_busy_has_token: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> ((|tok_valid) || done_q))
		else $error("busy with no reference in flight");

	// A result never reports both a hit and an eviction.
	a_hit_no_evict: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(out_hit_q && out_evict_q))
		else $error("hit reported together with an eviction");

	// A completed fault leaves a nonzero count unless a restart cleared it.
	a_fault_counts: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && !done_hit_q && !clear) |=> (faults_q != '0))
		else $error("fault did not advance the fault counter");
`endif

endmodule
